// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, masked while reset is held.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on the rising clock edge, masked while reset is held.
`define CHK_IMPLY(lbl, ante, cons, msg) \
    `CHK_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/lru_pkg.sv =====
// Package with command and status codes of the LRU replacement tracker.
package lru_pkg;

    localparam int KEY_PORT_W = 32;

    typedef enum logic [1:0]
    {
        CMD_INSERT = 2'd0,
        CMD_EVICT  = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_NONE   = 2'd3
    } lru_cmd_t;

    typedef enum logic [1:0]
    {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } lru_status_t;

endpackage

// ===== design/lru_replacement_tracker.sv =====
// LRU replacement tracker: recency-ordered key store held in one memory.
//
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tuser: command, s_tdata: key
// m_axis    out        m_tvalid/m_tready  m_tuser: status, m_tdata: victim_key, entry_count
//
// Slots 0 .. count-1 of the key memory hold keys, least recent first.
// Insert and erase scan the slots up to the hit, then move each later slot down
// by one to close the gap; evict takes slot 0 and closes the gap the same way.
// Each slot moved is read and then written through the single read and single write port.
// Reset clears the count and the control state; the memory is not cleared.
// A new command is taken only in idle; a stalled result holds in the output register.
module lru_replacement_tracker
    import lru_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int DATA_W  = ((KEY_PORT_W + CNT_W + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] key
    input  logic [1:0]        s_tuser,   // [1:0] command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] victim_key, then entry_count, zero fill
    output logic [1:0]        m_tuser    // [1:0] status
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_TAIL,
        S_APPEND,
        S_FINISH
    } state_t;

    state_t               state_reg;
    lru_cmd_t             op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [CNT_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    lru_status_t          status_reg;
    logic [KEY_BITS-1:0]  victim_reg;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [DATA_W-1:0]    m_data_reg;
    logic [1:0]           m_user_reg;

    // Key memory: one write and one registered read per cycle.
    logic [KEY_BITS-1:0]  mem [CAPACITY];
    logic [KEY_BITS-1:0]  rdata_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [KEY_BITS-1:0]  wr_data;
    logic                 wr_en;

    logic [CNT_W-1:0]     ptr_inc;
    logic                 hit;

    assign ptr_inc = ptr_reg + CNT_W'(1);
    assign hit     = (op_reg == CMD_EVICT) || (rdata_reg == key_reg);

    // Read the scanned slot, or the slot above it while closing the gap.
    always_comb
    begin
        rd_addr = (state_reg == S_SHRD) ? ptr_inc[AW-1:0] : ptr_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = ptr_reg[AW-1:0];
        wr_data = rdata_reg;
        case (state_reg)
            S_SHWR:
            begin
                wr_en = 1'b1;
            end
            S_TAIL:
            begin
                wr_en   = (op_reg == CMD_INSERT);
                wr_addr = ptr_reg[AW-1:0];
                wr_data = key_reg;
            end
            S_APPEND:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[AW-1:0];
                wr_data = key_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Drop the result on its transaction; raise it when a command finishes.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (state_reg == S_FINISH && (!m_valid_reg || m_tready))
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            op_reg      <= CMD_NONE;
            key_reg     <= '0;
            ptr_reg     <= '0;
            status_reg  <= ST_DONE;
            victim_reg  <= '0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg     <= lru_cmd_t'(s_tuser);
                        key_reg    <= KEY_BITS'(s_tdata);
                        ptr_reg    <= '0;
                        status_reg <= ST_DONE;
                        victim_reg <= '0;
                        case (lru_cmd_t'(s_tuser))
                            CMD_INSERT:
                            begin
                                state_reg <= (cnt_reg == '0) ? S_APPEND : S_RD;
                            end
                            CMD_EVICT, CMD_ERASE:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    status_reg <= ST_MISS;
                                    state_reg  <= S_FINISH;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (hit)
                    begin
                        if (op_reg == CMD_EVICT)
                        begin
                            victim_reg <= rdata_reg;
                        end
                        state_reg <= (ptr_inc < cnt_reg) ? S_SHRD : S_TAIL;
                    end
                    else if (ptr_inc < cnt_reg)
                    begin
                        ptr_reg   <= ptr_inc;
                        state_reg <= S_RD;
                    end
                    else if (op_reg == CMD_INSERT)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_APPEND;
                        end
                    end
                    else
                    begin
                        status_reg <= ST_MISS;
                        state_reg  <= S_FINISH;
                    end
                end
                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    ptr_reg   <= ptr_inc;
                    state_reg <= ((ptr_inc + CNT_W'(1)) < cnt_reg) ? S_SHRD : S_TAIL;
                end
                S_TAIL:
                begin
                    if (op_reg != CMD_INSERT)
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                    state_reg <= S_FINISH;
                end
                S_APPEND:
                begin
                    cnt_reg   <= cnt_reg + CNT_W'(1);
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // Hold until the output register is free.
                    if (!m_valid_reg || m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && (!m_valid_reg || m_tready))
        begin
            m_data_reg <= DATA_W'({cnt_reg, KEY_PORT_W'(victim_reg)});
            m_user_reg <= status_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== design/lru_checker.sv =====
// Port-level checker for the LRU replacement tracker, bound to the tracker module.
`include "assert_macros.svh"

module lru_checker
    import lru_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int DATA_W   = 40,
    parameter int CNT_W    = 7
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [1:0]        m_tuser
);

    logic [CNT_W-1:0] count;
    assign count = m_tdata[KEY_PORT_W +: CNT_W];

    `CHK_IMPLY(a_count_bound, m_tvalid, count <= CNT_W'(CAPACITY), "count above capacity")
    `CHK_IMPLY(a_status_code, m_tvalid, m_tuser != ST_RSVD, "reserved status code")
    `CHK_IMPLY(a_victim_zero, m_tvalid && m_tuser != ST_DONE,
        m_tdata[KEY_PORT_W-1:0] == '0, "victim key set on failed command")
    `CHK_IMPLY(a_full_count, m_tvalid && m_tuser == ST_FULL,
        count == CNT_W'(CAPACITY), "full status without full store")
    `CHK_IMPLY(a_out_hold, m_tvalid && !m_tready,
        ##1 (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind lru_replacement_tracker lru_checker #(
    .CAPACITY (CAPACITY),
    .DATA_W   (DATA_W),
    .CNT_W    (CNT_W)
) u_lru_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
